### sv/irp_pkg.sv
// shared types and constants for the icmp reply parser
package irp_pkg;

    // byte-count field width in the packet record, covers the largest packet limit
    localparam int LEN_W = 16;
    localparam int DEF_MAX_PACKET = 1024;
    localparam int DEF_STAMP_BYTES = 16;
    localparam int ICMP_HDR = 8;
    localparam int MIN_IP_HDR = 20;
    localparam int QUEUE_DEPTH = 2;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [10:0] ILEN_MAX = 11'h7FF;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_OWN_ID       = 2'd0,
        CFG_EXPECTED_SEQ = 2'd1,
        CFG_VERBOSE      = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_MALFORMED  = 2'd0,
        ST_ECHO_REPLY = 2'd1,
        ST_ERROR      = 2'd2,
        ST_IGNORED    = 2'd3
    } status_t;

    localparam logic [7:0] ICMP_ECHO_REPLY   = 8'd0;
    localparam logic [7:0] ICMP_UNREACHABLE  = 8'd3;
    localparam logic [7:0] ICMP_SLOW_DOWN    = 8'd4;
    localparam logic [7:0] ICMP_ROUTE_CHANGE = 8'd5;
    localparam logic [7:0] ICMP_TTL_EXPIRED  = 8'd11;
    localparam logic [7:0] ICMP_PARAM_PROBLEM = 8'd12;

    // one captured packet, handed from the capture side to the result side
    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [5:0]       olen;
        logic [5:0]       ilen;
        logic [7:0]       ttl;
        logic [7:0]       icmp_type;
        logic [7:0]       code;
        logic [15:0]      id;
        logic [15:0]      seq;
        logic [15:0]      iseq;
        logic [63:0]      sec;
        logic [63:0]      usec;
    } pkt_rec_t;

endpackage

### sv/irp_front.sv
// byte capture: walks the packet and snapshots header fields at the last byte
module irp_front import irp_pkg::*; #(
    parameter int MAX_PACKET  = DEF_MAX_PACKET,
    parameter int STAMP_BYTES = DEF_STAMP_BYTES
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_last_byte,
    output logic       push_valid,
    input  logic       push_ready,
    output pkt_rec_t   push_rec
);

    localparam int CNT_W = $clog2(MAX_PACKET + 1);
    localparam int CMP_W = ((CNT_W > 8) ? CNT_W : 8) + 1;
    localparam int HALF  = STAMP_BYTES / 2;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [5:0]       olen_reg, olen_next;
    logic [5:0]       ilen_reg, ilen_next;
    logic [7:0]       ttl_reg, ttl_next;
    logic [7:0]       type_reg, type_next;
    logic [7:0]       code_reg, code_next;
    logic [15:0]      id_reg, id_next;
    logic [15:0]      seq_reg, seq_next;
    logic [15:0]      iseq_reg, iseq_next;
    logic [63:0]      sec_reg, sec_next;
    logic [63:0]      usec_reg, usec_next;

    logic             accept;
    logic             cap;
    logic [5:0]       h_cur;
    logic [CMP_W-1:0] pos, h_ext, hb8, inner, k_full;
    logic             stamp_hit;

    assign s_ready    = push_ready;
    assign accept     = s_valid && s_ready;
    assign push_valid = accept && s_last_byte;

    always_comb begin
        cap    = accept && (count_reg < CNT_W'(MAX_PACKET));
        pos    = CMP_W'(count_reg);
        // the header length nibble is live on byte 0 itself
        h_cur  = (count_reg == '0) ? {s_data_byte[3:0], 2'b00} : olen_reg;
        h_ext  = CMP_W'(h_cur);
        hb8    = h_ext + CMP_W'(ICMP_HDR);
        inner  = hb8 + CMP_W'(ilen_reg);
        k_full = pos - hb8;
        stamp_hit = cap && (pos >= hb8) && (k_full < CMP_W'(STAMP_BYTES));

        count_next = count_reg;
        olen_next  = olen_reg;
        ilen_next  = ilen_reg;
        ttl_next   = ttl_reg;
        type_next  = type_reg;
        code_next  = code_reg;
        id_next    = id_reg;
        seq_next   = seq_reg;
        iseq_next  = iseq_reg;
        sec_next   = sec_reg;
        usec_next  = usec_reg;

        if (cap) begin
            count_next = count_reg + 1'b1;
            olen_next  = h_cur;
            if (pos == CMP_W'(8))          ttl_next = s_data_byte;
            if (pos == h_ext)              type_next = s_data_byte;
            if (pos == h_ext + CMP_W'(1))  code_next = s_data_byte;
            if (pos == h_ext + CMP_W'(4))  id_next[15:8] = s_data_byte;
            if (pos == h_ext + CMP_W'(5))  id_next[7:0] = s_data_byte;
            if (pos == h_ext + CMP_W'(6))  seq_next[15:8] = s_data_byte;
            if (pos == h_ext + CMP_W'(7))  seq_next[7:0] = s_data_byte;
            if (pos == hb8)                ilen_next = {s_data_byte[3:0], 2'b00};
            if (pos == inner + CMP_W'(6))  iseq_next[15:8] = s_data_byte;
            if (pos == inner + CMP_W'(7))  iseq_next[7:0] = s_data_byte;
        end

        // timestamp bytes land in little-endian byte lanes
        for (int i = 0; i < 8; i++) begin
            if (stamp_hit && (k_full < CMP_W'(HALF)) && (k_full == CMP_W'(i)))
                sec_next[8*i +: 8] = s_data_byte;
            if (stamp_hit && (k_full == CMP_W'(HALF + i)))
                usec_next[8*i +: 8] = s_data_byte;
        end

        push_rec.len       = LEN_W'(count_next);
        push_rec.olen      = olen_next;
        push_rec.ilen      = ilen_next;
        push_rec.ttl       = ttl_next;
        push_rec.icmp_type = type_next;
        push_rec.code      = code_next;
        push_rec.id        = id_next;
        push_rec.seq       = seq_next;
        push_rec.iseq      = iseq_next;
        push_rec.sec       = sec_next;
        push_rec.usec      = usec_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || push_valid) begin
            count_reg <= '0;
            olen_reg  <= '0;
            ilen_reg  <= '0;
            ttl_reg   <= '0;
            type_reg  <= '0;
            code_reg  <= '0;
            id_reg    <= '0;
            seq_reg   <= '0;
            iseq_reg  <= '0;
            sec_reg   <= '0;
            usec_reg  <= '0;
        end else begin
            count_reg <= count_next;
            olen_reg  <= olen_next;
            ilen_reg  <= ilen_next;
            ttl_reg   <= ttl_next;
            type_reg  <= type_next;
            code_reg  <= code_next;
            id_reg    <= id_next;
            seq_reg   <= seq_next;
            iseq_reg  <= iseq_next;
            sec_reg   <= sec_next;
            usec_reg  <= usec_next;
        end
    end

endmodule

### sv/irp_queue.sv
// short record queue between capture and result sides
module irp_queue import irp_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push_valid,
    output logic     push_ready,
    input  pkt_rec_t push_rec,
    output logic     pop_valid,
    input  logic     pop_ready,
    output pkt_rec_t pop_rec
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    pkt_rec_t           entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic               do_push, do_pop;

    assign push_ready = (fill_reg != FILL_W'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_rec    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        fill_next = fill_reg + FILL_W'(do_push) - FILL_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_rec;
    end

endmodule

### sv/irp_back.sv
// result side: classifies a captured packet and holds the result for the consumer
module irp_back import irp_pkg::*; #(
    parameter int STAMP_BYTES = DEF_STAMP_BYTES
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  pop_valid,
    output logic                  pop_ready,
    input  pkt_rec_t              pop_rec,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_status,
    output logic [7:0]            m_ttl,
    output logic [7:0]            m_icmp_type,
    output logic [7:0]            m_icmp_code,
    output logic [15:0]           m_echo_id,
    output logic [15:0]           m_echo_seq,
    output logic [10:0]           m_icmp_length,
    output logic                  m_stamp_valid,
    output logic [63:0]           m_send_seconds,
    output logic [63:0]           m_send_microseconds,
    output logic [15:0]           m_original_seq
);

    localparam int CW = LEN_W + 1;

    logic [15:0] own_id_reg;
    logic [15:0] exp_seq_reg;
    logic        verbose_reg;

    logic        out_valid_reg, out_valid_next;
    status_t     status_reg, status_next;
    logic [7:0]  ttl_reg, ttl_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  code_reg, code_next;
    logic [15:0] id_reg, id_next;
    logic [15:0] seq_reg, seq_next;
    logic [10:0] ilen_reg, ilen_next;
    logic        stamp_reg, stamp_next;
    logic [63:0] sec_reg, sec_next;
    logic [63:0] usec_reg, usec_next;
    logic [15:0] orig_reg, orig_next;

    logic          load;
    logic [CW-1:0] len, hb8;
    logic [LEN_W-1:0] diff;
    logic          malformed, is_error_type, inner_ok;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_id_reg  <= '0;
            exp_seq_reg <= '0;
            verbose_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_addr)
                CFG_OWN_ID:       own_id_reg  <= cfg_data;
                CFG_EXPECTED_SEQ: exp_seq_reg <= cfg_data;
                CFG_VERBOSE:      verbose_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign pop_ready = !out_valid_reg || m_ready;
    assign load      = pop_valid && pop_ready;

    always_comb begin
        len  = CW'(pop_rec.len);
        hb8  = CW'(pop_rec.olen) + CW'(ICMP_HDR);
        diff = pop_rec.len - LEN_W'(pop_rec.olen);
        malformed = len < hb8;
        is_error_type = pop_rec.icmp_type inside {ICMP_UNREACHABLE, ICMP_SLOW_DOWN,
                                                  ICMP_ROUTE_CHANGE, ICMP_TTL_EXPIRED,
                                                  ICMP_PARAM_PROBLEM};
        // embedded header must hold a minimal ip header and the inner icmp sequence
        inner_ok = (len >= hb8 + CW'(MIN_IP_HDR)) &&
                   (len >= hb8 + CW'(pop_rec.ilen) + CW'(ICMP_HDR));

        out_valid_next = out_valid_reg;
        if (load)
            out_valid_next = 1'b1;
        else if (m_ready)
            out_valid_next = 1'b0;

        status_next = ST_IGNORED;
        orig_next   = '0;
        if (malformed) begin
            status_next = ST_MALFORMED;
        end else if (pop_rec.icmp_type == ICMP_ECHO_REPLY && pop_rec.id == own_id_reg &&
                     pop_rec.seq == exp_seq_reg) begin
            status_next = ST_ECHO_REPLY;
        end else if (verbose_reg && is_error_type) begin
            status_next = ST_ERROR;
            if (inner_ok)
                orig_next = pop_rec.iseq;
        end

        stamp_next = !malformed && (len >= hb8 + CW'(STAMP_BYTES));
        ttl_next   = malformed ? '0 : pop_rec.ttl;
        type_next  = malformed ? '0 : pop_rec.icmp_type;
        code_next  = malformed ? '0 : pop_rec.code;
        id_next    = malformed ? '0 : pop_rec.id;
        seq_next   = malformed ? '0 : pop_rec.seq;
        if (malformed)
            ilen_next = '0;
        else if (diff > LEN_W'(ILEN_MAX))
            ilen_next = ILEN_MAX;
        else
            ilen_next = diff[10:0];
        sec_next  = stamp_next ? pop_rec.sec : '0;
        usec_next = stamp_next ? pop_rec.usec : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            status_reg <= status_next;
            ttl_reg    <= ttl_next;
            type_reg   <= type_next;
            code_reg   <= code_next;
            id_reg     <= id_next;
            seq_reg    <= seq_next;
            ilen_reg   <= ilen_next;
            stamp_reg  <= stamp_next;
            sec_reg    <= sec_next;
            usec_reg   <= usec_next;
            orig_reg   <= orig_next;
        end
    end

    assign m_valid             = out_valid_reg;
    assign m_status            = status_reg;
    assign m_ttl               = ttl_reg;
    assign m_icmp_type         = type_reg;
    assign m_icmp_code         = code_reg;
    assign m_echo_id           = id_reg;
    assign m_echo_seq          = seq_reg;
    assign m_icmp_length       = ilen_reg;
    assign m_stamp_valid       = stamp_reg;
    assign m_send_seconds      = sec_reg;
    assign m_send_microseconds = usec_reg;
    assign m_original_seq      = orig_reg;

endmodule

### sv/icmp_reply_parser.sv
// top level of the icmp echo reply parser
//
//   channel   direction  handshake              carries
//   s_*       in         s_valid / s_ready      one packet byte and its last flag
//   m_*       out        m_valid / m_ready      one parse result per packet
//   cfg_*     in         cfg_valid / cfg_ready  register index and write data
//
// one byte per cycle while the queue is not full; the last byte's capture snapshot goes into
// a two-entry queue, then the classify stage loads the output register that drives m_valid.
// reset is synchronous, active low, and clears all capture state and the queue.
// a stalled result output fills the queue; while the queue is full every byte stalls.
// cfg_ready is always high.
module icmp_reply_parser import irp_pkg::*; #(
    parameter int MAX_PACKET  = DEF_MAX_PACKET,
    parameter int STAMP_BYTES = DEF_STAMP_BYTES
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_data_byte,
    input  logic                  s_last_byte,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_status,
    output logic [7:0]            m_ttl,
    output logic [7:0]            m_icmp_type,
    output logic [7:0]            m_icmp_code,
    output logic [15:0]           m_echo_id,
    output logic [15:0]           m_echo_seq,
    output logic [10:0]           m_icmp_length,
    output logic                  m_stamp_valid,
    output logic [63:0]           m_send_seconds,
    output logic [63:0]           m_send_microseconds,
    output logic [15:0]           m_original_seq
);

    logic     push_valid, push_ready;
    pkt_rec_t push_rec;
    logic     pop_valid, pop_ready;
    pkt_rec_t pop_rec;

    irp_front #(
        .MAX_PACKET  (MAX_PACKET),
        .STAMP_BYTES (STAMP_BYTES)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_last_byte (s_last_byte),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_rec    (push_rec)
    );

    irp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_rec   (push_rec),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_rec    (pop_rec)
    );

    irp_back #(
        .STAMP_BYTES (STAMP_BYTES)
    ) u_back (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_addr            (cfg_addr),
        .cfg_data            (cfg_data),
        .pop_valid           (pop_valid),
        .pop_ready           (pop_ready),
        .pop_rec             (pop_rec),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_status            (m_status),
        .m_ttl               (m_ttl),
        .m_icmp_type         (m_icmp_type),
        .m_icmp_code         (m_icmp_code),
        .m_echo_id           (m_echo_id),
        .m_echo_seq          (m_echo_seq),
        .m_icmp_length       (m_icmp_length),
        .m_stamp_valid       (m_stamp_valid),
        .m_send_seconds      (m_send_seconds),
        .m_send_microseconds (m_send_microseconds),
        .m_original_seq      (m_original_seq)
    );

endmodule

### sv/irp_checker.sv
// port-level checks for the icmp reply parser, bound to the top level
module irp_checker import irp_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_status,
    input logic [10:0] m_icmp_length,
    input logic [15:0] m_echo_id,
    input logic        m_stamp_valid,
    input logic [63:0] m_send_seconds,
    input logic [63:0] m_send_microseconds,
    input logic [15:0] m_original_seq
);

    // a held result keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_send_seconds))
        else $error("result changed while stalled");

    a_malformed_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_MALFORMED |->
            m_icmp_length == '0 && m_echo_id == '0 && !m_stamp_valid)
        else $error("malformed result carries fields");

    a_no_stamp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_stamp_valid |-> m_send_seconds == '0 && m_send_microseconds == '0)
        else $error("timestamp words without timestamp");

    a_orig_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_ERROR |-> m_original_seq == '0)
        else $error("original sequence outside error result");

endmodule

bind icmp_reply_parser irp_checker u_irp_checker (
    .aclk                (aclk),
    .aresetn             (aresetn),
    .m_valid             (m_valid),
    .m_ready             (m_ready),
    .m_status            (m_status),
    .m_icmp_length       (m_icmp_length),
    .m_echo_id           (m_echo_id),
    .m_stamp_valid       (m_stamp_valid),
    .m_send_seconds      (m_send_seconds),
    .m_send_microseconds (m_send_microseconds),
    .m_original_seq      (m_original_seq)
);
